// ----- sv/shabh_pkg.sv -----
// Shared types, constants and round functions for the SHA-256 byte hasher.
package shabh_pkg;

    typedef logic [31:0] t_word;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PAD   = 7'b0000010,
        ST_LOAD  = 7'b0000100,
        ST_ROUND = 7'b0001000,
        ST_FOLD  = 7'b0010000,
        ST_ORD   = 7'b0100000,
        ST_OWR   = 7'b1000000
    } t_state;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] LAST_BYTE = 6'd63;
    localparam logic [63:0] BLOCK_BITS = 64'd512;

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word ror(input t_word v, input int n);
        ror = (v >> n) | (v << (32 - n));
    endfunction

endpackage

// ----- sv/shabh_round.sv -----
// One SHA-256 round and one message schedule step.
module shabh_round (
    input  shabh_pkg::t_word i_v [8],
    input  shabh_pkg::t_word i_w [16],
    input  shabh_pkg::t_word i_k,
    output shabh_pkg::t_word o_v [8],
    output shabh_pkg::t_word o_w_new
);
    shabh_pkg::t_word big0, big1, ch, maj, t1, sig0, sig1;

    // Compression round on the working words
    always_comb begin
        big1 = shabh_pkg::ror(i_v[4], 6) ^ shabh_pkg::ror(i_v[4], 11)
             ^ shabh_pkg::ror(i_v[4], 25);
        ch   = (i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6]);
        t1   = i_v[7] + big1 + ch + i_k + i_w[0];
        big0 = shabh_pkg::ror(i_v[0], 2) ^ shabh_pkg::ror(i_v[0], 13)
             ^ shabh_pkg::ror(i_v[0], 22);
        maj  = (i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]);
        o_v[7] = i_v[6];
        o_v[6] = i_v[5];
        o_v[5] = i_v[4];
        o_v[4] = i_v[3] + t1;
        o_v[3] = i_v[2];
        o_v[2] = i_v[1];
        o_v[1] = i_v[0];
        o_v[0] = t1 + big0 + maj;
    end

    // Next schedule word from the sixteen-word window
    always_comb begin
        sig0 = shabh_pkg::ror(i_w[1], 7) ^ shabh_pkg::ror(i_w[1], 18) ^ (i_w[1] >> 3);
        sig1 = shabh_pkg::ror(i_w[14], 17) ^ shabh_pkg::ror(i_w[14], 19)
             ^ (i_w[14] >> 10);
        o_w_new = i_w[0] + sig0 + i_w[9] + sig1;
    end
endmodule

// ----- sv/sha256_byte_hasher_top.sv -----
// SHA-256 byte hasher: block buffer and chaining state in memories.
// Input channel: i_valid / o_stall carries i_action and i_data_byte. An
// absorb word writes one byte into the block buffer. Every 64th byte
// starts a compression: the schedule window and the chaining words are
// loaded, the rounds run on the single round unit and the result is
// folded back into the chaining memory. Input stalls until it is done.
// A finish word writes the padding one byte per cycle (two blocks when
// more than 55 bytes are buffered), compresses, then reads out the
// digest: eight words on o_valid / i_stall, word 0 first, o_last_word
// on word 7, each word read from the chaining memory before the output
// register takes it; input stalls during the read-out.
// A stalled output word holds; the output register lets the next input
// word be taken while the last digest word still waits.
// Reset (synchronous, active low) restores the initial hash values via
// per-entry valid bits, clears the byte and bit counts; no clearing pass.
module sha256_byte_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    shabh_pkg::t_state r_state;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [63:0] r_total;
    logic [5:0]  r_pidx;
    logic        r_put80;
    logic        r_extra;
    logic        r_fin;
    logic [6:0]  r_cnt;
    logic [2:0]  r_oidx;

    shabh_pkg::t_word r_v [8];
    shabh_pkg::t_word r_w [16];
    shabh_pkg::t_word n_v [8];
    shabh_pkg::t_word w_new;

    // Memories
    shabh_pkg::t_word r_buf [16];
    shabh_pkg::t_word r_hmem [8];
    logic [7:0]       r_hval;
    shabh_pkg::t_word r_buf_rd;
    shabh_pkg::t_word r_h_rd;
    logic             r_h_rv;
    logic [2:0]       r_h_ra;

    logic       in_acc;
    logic       buf_we;
    logic [5:0] buf_wi;
    logic [7:0] buf_wb;
    logic [3:0] buf_ra;
    logic [2:0] h_ra;
    logic       h_we;
    logic [2:0] h_wa;
    shabh_pkg::t_word h_word;
    shabh_pkg::t_word h_wd;
    logic [2:0] len_k;
    logic       out_free;

    assign in_acc   = i_valid && !o_stall;
    assign o_stall  = (r_state != shabh_pkg::ST_IDLE);
    assign out_free = !o_valid || !i_stall;
    assign h_word   = r_h_rv ? r_h_rd : shabh_pkg::INIT_H[r_h_ra];
    assign len_k    = ~r_pidx[2:0];

    // Byte write into the block buffer
    always_comb begin
        buf_we = 1'b0;
        buf_wi = r_pidx;
        buf_wb = 8'h00;
        if (r_state == shabh_pkg::ST_IDLE) begin
            buf_we = in_acc && (i_action == shabh_pkg::ACT_ABSORB);
            buf_wi = r_fill;
            buf_wb = i_data_byte;
        end else if (r_state == shabh_pkg::ST_PAD) begin
            buf_we = 1'b1;
            if (r_put80) begin
                buf_wb = shabh_pkg::PAD_MARK;
            end else if (!r_extra && r_pidx >= shabh_pkg::LEN_START) begin
                buf_wb = r_total[{len_k, 3'b000} +: 8];
            end
        end
    end

    // Read addresses and chaining write-back
    always_comb begin
        buf_ra = r_cnt[3:0];
        h_ra   = (r_state == shabh_pkg::ST_ORD || r_state == shabh_pkg::ST_OWR)
               ? r_oidx : r_cnt[2:0];
        h_we   = (r_state == shabh_pkg::ST_FOLD) && (r_cnt != 7'd0);
        h_wa   = 3'(r_cnt - 7'd1);
        h_wd   = h_word + r_v[h_wa];
    end

    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            r_buf[buf_wi[5:2]][{~buf_wi[1:0], 3'b000} +: 8] <= buf_wb;
        end
        r_buf_rd <= r_buf[buf_ra];
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            r_hmem[h_wa] <= h_wd;
        end
        r_h_rd <= r_hmem[h_ra];
        r_h_ra <= h_ra;
        r_h_rv <= r_hval[h_ra];
    end

    shabh_round u_round (
        .i_v     (r_v),
        .i_w     (r_w),
        .i_k     (shabh_pkg::ROUND_K[r_cnt[5:0]]),
        .o_v     (n_v),
        .o_w_new (w_new)
    );

    // Datapath registers: working words and schedule window
    always_ff @(posedge i_clk) begin
        if (r_state == shabh_pkg::ST_LOAD && r_cnt != 7'd0) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= r_buf_rd;
            if (r_cnt <= 7'd8) begin
                for (int i = 0; i < 7; i++) r_v[i] <= r_v[i+1];
                r_v[7] <= h_word;
            end
        end else if (r_state == shabh_pkg::ST_ROUND) begin
            r_v <= n_v;
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end
    end

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shabh_pkg::ST_IDLE;
            r_fill  <= '0;
            r_bits  <= '0;
            r_hval  <= '0;
            r_cnt   <= '0;
            r_oidx  <= '0;
            r_put80 <= 1'b0;
            r_extra <= 1'b0;
            r_fin   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            // Drop a taken word unless the read-out stage replaces it
            if (o_valid && !i_stall && r_state != shabh_pkg::ST_OWR) o_valid <= 1'b0;
            if (h_we) r_hval[h_wa] <= 1'b1;
            unique case (r_state)
                shabh_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        if (i_action == shabh_pkg::ACT_ABSORB) begin
                            r_fill <= r_fill + 6'd1;
                            if (r_fill == shabh_pkg::LAST_BYTE) begin
                                r_fin   <= 1'b0;
                                r_cnt   <= '0;
                                r_state <= shabh_pkg::ST_LOAD;
                            end
                        end else begin
                            r_total <= r_bits + {55'd0, r_fill, 3'b000};
                            r_pidx  <= r_fill;
                            r_put80 <= 1'b1;
                            r_extra <= (r_fill >= shabh_pkg::LEN_START);
                            r_fin   <= 1'b1;
                            r_state <= shabh_pkg::ST_PAD;
                        end
                    end
                end
                shabh_pkg::ST_PAD: begin
                    r_put80 <= 1'b0;
                    r_pidx  <= r_pidx + 6'd1;
                    if (r_pidx == shabh_pkg::LAST_BYTE) begin
                        r_cnt   <= '0;
                        r_state <= shabh_pkg::ST_LOAD;
                    end
                end
                shabh_pkg::ST_LOAD: begin
                    if (r_cnt == 7'd16) begin
                        r_cnt   <= '0;
                        r_state <= shabh_pkg::ST_ROUND;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                shabh_pkg::ST_ROUND: begin
                    if (r_cnt == 7'd63) begin
                        r_cnt   <= '0;
                        r_state <= shabh_pkg::ST_FOLD;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                shabh_pkg::ST_FOLD: begin
                    if (r_cnt == 7'd8) begin
                        r_cnt <= '0;
                        if (!r_fin) begin
                            r_bits  <= r_bits + shabh_pkg::BLOCK_BITS;
                            r_state <= shabh_pkg::ST_IDLE;
                        end else if (r_extra) begin
                            r_extra <= 1'b0;
                            r_pidx  <= '0;
                            r_state <= shabh_pkg::ST_PAD;
                        end else begin
                            r_oidx  <= '0;
                            r_state <= shabh_pkg::ST_ORD;
                        end
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                shabh_pkg::ST_ORD: begin
                    r_state <= shabh_pkg::ST_OWR;
                end
                shabh_pkg::ST_OWR: begin
                    if (out_free) begin
                        o_valid       <= 1'b1;
                        o_digest_word <= h_word;
                        o_word_index  <= r_oidx;
                        o_last_word   <= (r_oidx == 3'd7);
                        r_oidx        <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_hval  <= '0;
                            r_fill  <= '0;
                            r_bits  <= '0;
                            r_state <= shabh_pkg::ST_IDLE;
                        end else begin
                            r_state <= shabh_pkg::ST_ORD;
                        end
                    end
                end
                default: r_state <= shabh_pkg::ST_IDLE;
            endcase
        end
    end
endmodule

// ----- sv/shabh_checker.sv -----
// Port-level checks for the SHA-256 byte hasher, bound to the top level.
module shabh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);
    // Flag the final word exactly at index seven
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last_word flag disagrees with word index");

    // Advance the word index by one between consecutive digest words
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> (!o_valid || o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest words out of order");

    // Hold a stalled word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_digest_word)
                                  && $stable(o_word_index)))
        else $error("stalled digest word changed");

    // Drop valid and stall out of reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_valid && !o_stall))
        else $error("block not idle after reset");
endmodule

bind sha256_byte_hasher_top shabh_checker u_shabh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);

// ----- verif/tb.sv -----
// Self-checking testbench for the SHA-256 byte hasher: directed table, random messages, digests.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic       act;
        logic [7:0] data;
        logic       chk;
        shabh_pkg::t_word w0;
    } t_row;

    typedef struct {
        shabh_pkg::t_word word;
        logic [2:0] idx;
        logic       last;
    } t_digest_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_action = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    // Hasher model state
    shabh_pkg::t_word hash_state [8];
    logic [7:0]  msg_block [64];
    int unsigned block_fill;
    logic [63:0] hashed_bits;

    t_digest_out digest_queue [$];
    shabh_pkg::t_word known_w0 [$];
    int          errors = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          digests_seen = 0;
    int          cycles = 0;
    int          send_idle = 35;
    int          recv_idle = 84;
    bit          hold_recv = 1'b0;

    sha256_byte_hasher_top dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic shabh_pkg::t_word rotr(shabh_pkg::t_word v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // Compress the held block into the chaining words
    function automatic void compress_msg_block();
        shabh_pkg::t_word w [64];
        shabh_pkg::t_word v [8];
        shabh_pkg::t_word t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + shabh_pkg::ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int j = 7; j > 0; j--) v[j] = v[j-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++) hash_state[i] = shabh_pkg::INIT_H[i];
        block_fill = 0;
        hashed_bits = '0;
    endfunction

    // Advance the model by one accepted word; queue the digest on finish
    function automatic void predict_hasher(logic act, logic [7:0] data);
        logic [63:0] total;
        int unsigned p;
        if (act == shabh_pkg::ACT_ABSORB) begin
            msg_block[block_fill] = data;
            block_fill = (block_fill + 1) % 64;
            if (block_fill == 0) begin
                compress_msg_block();
                hashed_bits += shabh_pkg::BLOCK_BITS;
            end
            return;
        end
        total = hashed_bits + 64'(block_fill) * 8;
        p = block_fill;
        msg_block[p++] = shabh_pkg::PAD_MARK;
        if (p > shabh_pkg::LEN_START) begin
            while (p < 64) msg_block[p++] = 8'h00;
            compress_msg_block();
            p = 0;
        end
        while (p < shabh_pkg::LEN_START) msg_block[p++] = 8'h00;
        for (int i = 0; i < 8; i++)
            msg_block[shabh_pkg::LEN_START + i] = total[63 - 8*i -: 8];
        compress_msg_block();
        for (int i = 0; i < 8; i++)
            digest_queue.push_back('{hash_state[i], 3'(i), i == 7});
        restart_message();
    endfunction

    // Offer one word and hold it until taken
    task automatic send_word(logic act, logic [7:0] data);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_data_byte <= data;
        do @(posedge i_clk); while (o_stall);
        predict_hasher(act, data);
        words_in++;
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++) send_word(shabh_pkg::ACT_ABSORB, 8'($urandom));
        send_word(shabh_pkg::ACT_FINISH, 8'($urandom));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (digest_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Drive the output stall
    always @(posedge i_clk) begin
        i_stall <= hold_recv || (recv_idle > 0 && $urandom_range(99) < recv_idle);
    end

    // Check each accepted digest word against the oldest expectation
    always @(posedge i_clk) begin
        t_digest_out e;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            words_out++;
            if (digest_queue.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $time, o_digest_word);
                errors++;
            end else begin
                e = digest_queue.pop_front();
                if (o_word_index == 0 && known_w0.size() != 0) begin
                    if (o_digest_word !== known_w0[0]) begin
                        $display("%0t: known digest word0 expected %h actual %h",
                                 $time, known_w0[0], o_digest_word);
                        errors++;
                    end
                    void'(known_w0.pop_front());
                end
                if (o_digest_word !== e.word || o_word_index !== e.idx
                    || o_last_word !== e.last) begin
                    $display("%0t: expected %h/%0d/%b actual %h/%0d/%b", $time,
                             e.word, e.idx, e.last, o_digest_word, o_word_index,
                             o_last_word);
                    errors++;
                end
                if (o_last_word) digests_seen++;
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Directed table: "abc", empty, double finish, a short message
    t_row table_rows [$];

    initial begin
        int lens [2] = '{55, 56};
        restart_message();
        table_rows.push_back('{shabh_pkg::ACT_FINISH, 8'hff, 1'b1, 32'he3b0c442});
        table_rows.push_back('{shabh_pkg::ACT_FINISH, 8'h00, 1'b1, 32'he3b0c442});
        table_rows.push_back('{shabh_pkg::ACT_ABSORB, 8'h61, 1'b0, '0});
        table_rows.push_back('{shabh_pkg::ACT_ABSORB, 8'h62, 1'b0, '0});
        table_rows.push_back('{shabh_pkg::ACT_ABSORB, 8'h63, 1'b0, '0});
        table_rows.push_back('{shabh_pkg::ACT_FINISH, 8'h00, 1'b1, 32'hba7816bf});
        table_rows.push_back('{shabh_pkg::ACT_ABSORB, 8'h00, 1'b0, '0});
        table_rows.push_back('{shabh_pkg::ACT_ABSORB, 8'hff, 1'b0, '0});
        table_rows.push_back('{shabh_pkg::ACT_ABSORB, 8'haa, 1'b0, '0});
        table_rows.push_back('{shabh_pkg::ACT_ABSORB, 8'h55, 1'b0, '0});
        table_rows.push_back('{shabh_pkg::ACT_FINISH, 8'h5a, 1'b0, '0});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[r]) begin
            if (table_rows[r].chk) known_w0.push_back(table_rows[r].w0);
            send_word(table_rows[r].act, table_rows[r].data);
        end

        // Length edges around the padding boundary
        foreach (lens[k]) send_message(lens[k]);

        // Swap the idling, then a full block and short random messages
        send_idle = 84;
        recv_idle = 35;
        send_message(64);
        while (words_in < 200) send_message($urandom_range(0, 12));

        // Long receiver hold-off with the sender pushing on
        send_idle = 0;
        recv_idle = 0;
        fork
            begin
                hold_recv = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            repeat (4) send_message($urandom_range(0, 5));
        join
        wait_drained();
        repeat (2) send_message($urandom_range(0, 8));
        wait_drained();

        $display("Covered %0d input words and %0d digests (%0d words checked),",
                 words_in, digests_seen, words_out);
        $display("including padding edges, empty messages and back-pressure.");
        if (errors == 0 && digest_queue.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
sv/shabh_pkg.sv
sv/shabh_round.sv
sv/sha256_byte_hasher_top.sv
sv/shabh_checker.sv
verif/tb.sv
